>>> sv/fest_pkg.sv
package fest_pkg;

  // Table size default and the widest index it may need (up to 256 entries).
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int IDX_MAX_W         = 8;

  // Entries held between the lookup side and the update side.
  localparam int QUEUE_DEPTH = 2;

  // Header fields.
  localparam int ADDR_W   = 32;
  localparam int KIND_W   = 8;
  localparam int NUM_W    = 8;
  localparam int SEQ_W    = 32;
  localparam int CNT_W    = 16;
  localparam int UPT_W    = 32;
  localparam int KEY_W    = ADDR_W + KIND_W + NUM_W;
  localparam int IN_DATA_W = 128;

  // Result fields.
  localparam int SLOT_W     = 4;
  localparam int OUT_DATA_W = 72;

  // Per-entry sequence state: {uptime, next expected sequence}.
  localparam int ENTRY_W = UPT_W + SEQ_W;

  typedef struct packed {
    logic [IDX_MAX_W-1:0] slot;
    logic                 fresh;
    logic                 no_room;
    logic [SEQ_W-1:0]     seq;
    logic [CNT_W-1:0]     cnt;
    logic [UPT_W-1:0]     upt;
  } fest_item_t;

endpackage

>>> sv/fest_ram.sv
module fest_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/fest_front.sv
module fest_front #(
  parameter int TableEntries = fest_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [fest_pkg::IN_DATA_W-1:0] s_tdata_i,
  output logic                           push_o,
  output fest_pkg::fest_item_t           item_o,
  input  logic                           full_i
);
  import fest_pkg::*;

  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  logic [TableEntries-1:0] valid_q, valid_d;
  logic [KEY_W-1:0]        key_q [TableEntries];

  logic [ADDR_W-1:0] addr;
  logic [KIND_W-1:0] kind;
  logic [NUM_W-1:0]  num;
  logic [KEY_W-1:0]  key;
  logic              hit_found, free_found, accept;
  logic [IdxW-1:0]   hit_idx, free_idx;

  assign addr = s_tdata_i[31:0];
  assign kind = s_tdata_i[39:32];
  assign num  = s_tdata_i[47:40];
  assign key  = {addr, kind, num};

  // Lowest matching valid entry, lowest free entry.
  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int i = 0; i < TableEntries; i++) begin
      if (valid_q[i]) begin
        if (!hit_found && key_q[i] == key) begin
          hit_found = 1'b1;
          hit_idx   = IdxW'(i);
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  assign s_tready_o = !full_i;
  assign accept     = s_tvalid_i && !full_i;
  assign push_o     = accept;

  always_comb begin
    item_o.seq     = s_tdata_i[79:48];
    item_o.cnt     = s_tdata_i[95:80];
    item_o.upt     = s_tdata_i[127:96];
    item_o.fresh   = !hit_found && free_found;
    item_o.no_room = !hit_found && !free_found;
    if (hit_found) begin
      item_o.slot = IDX_MAX_W'(hit_idx);
    end else if (free_found) begin
      item_o.slot = IDX_MAX_W'(free_idx);
    end else begin
      item_o.slot = '0;
    end
  end

  // Allocation happens here so later lookups see it in order.
  always_comb begin
    valid_d = valid_q;
    if (accept && !hit_found && free_found) begin
      valid_d[free_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !hit_found && free_found) begin
      key_q[free_idx] <= key;
    end
  end

endmodule

>>> sv/fest_queue.sv
module fest_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  fest_pkg::fest_item_t item_i,
  output logic                 full_o,
  output logic                 valid_o,
  output fest_pkg::fest_item_t item_o,
  input  logic                 pop_i
);
  import fest_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  fest_item_t      mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> sv/fest_back.sv
module fest_back #(
  parameter int TableEntries = fest_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  fest_pkg::fest_item_t            item_i,
  output logic                            pop_o,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [fest_pkg::OUT_DATA_W-1:0] m_tdata_o
);
  import fest_pkg::*;

  localparam int AddrW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_e;

  state_e                  state_q;
  fest_item_t              item_q;
  logic                    m_valid_q;
  logic [OUT_DATA_W-1:0]   m_data_q;

  logic [ENTRY_W-1:0] rdata, wdata;
  logic [SEQ_W-1:0]   expect_seq, stored_upt, lost;
  logic               gap, restart, out_free, finish, wr_en;
  logic [OUT_DATA_W-1:0] result;

  assign pop_o    = (state_q == ST_IDLE) && valid_i;
  assign out_free = !m_valid_q || m_tready_i;
  assign finish   = (state_q == ST_CALC) && out_free;
  assign wr_en    = finish && !item_q.no_room;

  // A fresh entry reads as zero; its RAM word is never looked at.
  assign expect_seq = item_q.fresh ? '0 : rdata[SEQ_W-1:0];
  assign stored_upt = rdata[ENTRY_W-1:SEQ_W];
  assign gap        = (expect_seq != '0) && (item_q.seq != expect_seq);
  assign lost       = gap ? (item_q.seq - expect_seq) : '0;
  assign restart    = gap && (item_q.seq < expect_seq) && (item_q.upt < stored_upt);
  assign wdata      = {item_q.upt, item_q.seq + SEQ_W'(item_q.cnt)};

  always_comb begin
    if (item_q.no_room) begin
      result = '0;
      result[5] = 1'b1;
    end else begin
      result = {restart, expect_seq, lost, gap, 1'b0, item_q.fresh,
                item_q.slot[SLOT_W-1:0]};
    end
  end

  fest_ram #(
    .Width(ENTRY_W),
    .Depth(TableEntries)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(item_q.slot[AddrW-1:0]),
    .wdata_i(wdata),
    .re_i   (pop_o),
    .raddr_i(item_i.slot[AddrW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (valid_i) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (finish) begin
        m_valid_q <= 1'b1;
        m_data_q  <= result;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

endmodule

>>> sv/flow_export_sequence_tracker_core.sv
// Path: queue write on the header's transaction, then entry RAM read, check and
//   write-back, then the result register once the output is free.
// Update: one header at a time, with a read-then-write pass over the entry RAM
//   before the next is taken; lookups run ahead by up to 2 queued headers.
// Reset: clears entry valid bits, the queue and all handshake state; key and RAM
//   contents are not cleared and are only read after being written.
module flow_export_sequence_tracker_core #(
  parameter int TableEntries = fest_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Header stream.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [31:0] exporter_addr, [39:32] engine_kind, [47:40] engine_num,
  // [79:48] flow_seq, [95:80] record_count, [127:96] uptime_ms
  input  logic [fest_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // Result stream.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [3:0] slot, [4] was_new, [5] no_room, [6] gap_seen, [38:7] lost_flows,
  // [70:39] expected_seq, [71] restart_suspect
  output logic [fest_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import fest_pkg::*;

  // Front: key match over the entry table, allocation of the lowest free
  // entry on a miss. Owns the valid bits and keys, so every lookup sees
  // allocations made by earlier headers even before they are updated.
  fest_item_t push_item, head_item;
  logic       push, q_full, q_valid, pop;

  fest_front #(
    .TableEntries(TableEntries)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid_i),
    .s_tready_o(s_axis_tready_o),
    .s_tdata_i (s_axis_tdata_i),
    .push_o    (push),
    .item_o    (push_item),
    .full_i    (q_full)
  );

  // Short queue of classified headers; lets lookups continue while the
  // update side waits on the result stream.
  fest_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (q_full),
    .valid_o(q_valid),
    .item_o (head_item),
    .pop_i  (pop)
  );

  // Back: reads the entry's expected sequence and uptime, checks for a
  // gap or restart, writes sequence plus count and uptime, and holds the
  // result in an output register.
  fest_back #(
    .TableEntries(TableEntries)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .item_i    (head_item),
    .pop_o     (pop),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tready_i(m_axis_tready_i),
    .m_tdata_o (m_axis_tdata_o)
  );

endmodule
